>>> design/bgc_pkg.sv
// ---------------------------------------------------------------------------
// bgc_pkg: shared types and constants for the button gesture classifier
// timestamp width, action codes, register indexes and state/config structs
// ---------------------------------------------------------------------------
package bgc_pkg;

    localparam int TIME_W    = 32;   // internal timestamp width, 16..64
    localparam int STAMP_W   = 32;   // width of the timestamp port
    localparam int HOLD_W    = 32;   // width of the reported hold time
    localparam int CFG_W     = 16;   // width of each configuration register
    localparam int CFG_IDX_W = 2;    // register index width
    localparam int TAP_W     = 3;    // tap counter width

    localparam logic [TAP_W-1:0] TAP_MAX = TAP_W'(7);

    typedef enum logic [3:0] {
        ACT_NONE   = 4'd0,
        ACT_START  = 4'd1,
        ACT_NEXT   = 4'd2,
        ACT_CANCEL = 4'd3,
        ACT_PAUSE  = 4'd4,
        ACT_RESUME = 4'd5,
        ACT_RESET  = 4'd6,
        ACT_SELECT = 4'd7,
        ACT_MENU   = 4'd8
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_LONG      = 2'd1,
        CFG_VERY_LONG = 2'd2,
        CFG_TAP_GAP   = 2'd3
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_RST      = CFG_W'(1000);
    localparam logic [CFG_W-1:0] VERY_LONG_RST = CFG_W'(3000);
    localparam logic [CFG_W-1:0] TAP_GAP_RST   = CFG_W'(400);

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] very_long_press_ms;
        logic [CFG_W-1:0] tap_gap_ms;
    } bgc_cfg_t;

    typedef struct packed {
        logic              stable_level;
        logic [TIME_W-1:0] last_change;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] tap_start;
        logic [TAP_W-1:0]  tap_count;
    } bgc_state_t;

    typedef struct packed {
        action_t           action;
        logic              pressed;
        logic [HOLD_W-1:0] hold_ms;
    } bgc_result_t;

endpackage

>>> design/button_gesture_classifier.sv
// ---------------------------------------------------------------------------
// button_gesture_classifier: tap, long press and very long press detector
// the accepted sample waits in the input register, then is classified into
// the result register once that is free or its word is taken
// throughput: one sample per cycle while results are taken (state update loop)
// reset: asynchronous active low; released level, zero times, no pending taps,
// thresholds back to 50/1000/3000/400 ms
// ---------------------------------------------------------------------------
module button_gesture_classifier
    import bgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // sample channel
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic                 raw_level,
    input  logic [STAMP_W-1:0]   now_ms,
    // result channel
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [3:0]           action,
    output logic                 pressed,
    output logic [HOLD_W-1:0]    hold_ms
);

    bgc_cfg_t    cfg;
    bgc_state_t  state_reg;
    bgc_state_t  state_next;
    bgc_result_t step_res;
    bgc_result_t res_reg;

    // input register holding one sample word
    logic              in_valid_reg;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              res_valid_reg;

    logic advance;   // input word moves into the result register this cycle
    logic take_in;   // new sample word accepted this cycle

    bgc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .level      (in_level_reg),
        .now        (in_now_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // the result register frees up when its word is taken, so a full
    // pipeline keeps moving as long as the consumer takes a word per cycle
    assign advance      = in_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign take_in      = sample_valid && sample_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg.stable_level <= 1'b1;
            state_reg.last_change  <= '0;
            state_reg.press_start  <= '0;
            state_reg.tap_start    <= '0;
            state_reg.tap_count    <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_level_reg <= raw_level;
            in_now_reg   <= TIME_W'(now_ms);
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign action       = res_reg.action;
    assign pressed      = res_reg.pressed;
    assign hold_ms      = res_reg.hold_ms;

    // state only moves when a word is classified
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("gesture state changed without a classified word");

    // a released button never reports hold time
    a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.pressed |-> res_reg.hold_ms == '0)
        else $error("hold time reported while released");

    // press actions only come with a release
    a_press_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.action == ACT_MENU || res_reg.action == ACT_SELECT)
        |-> !res_reg.pressed)
        else $error("select or menu while button held");

    // an empty input register always takes a sample
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> sample_ready)
        else $error("sample refused with empty input register");

endmodule

>>> design/bgc_cfg.sv
// ---------------------------------------------------------------------------
// bgc_cfg: configuration register file
// four 16-bit timing thresholds written through a plain write port
// ---------------------------------------------------------------------------
module bgc_cfg
    import bgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output bgc_cfg_t             cfg
);

    bgc_cfg_t cfg_reg;
    bgc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:  cfg_next.debounce_ms        = cfg_data;
                CFG_LONG:      cfg_next.long_press_ms      = cfg_data;
                CFG_VERY_LONG: cfg_next.very_long_press_ms = cfg_data;
                CFG_TAP_GAP:   cfg_next.tap_gap_ms         = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.long_press_ms      <= LONG_RST;
            cfg_reg.very_long_press_ms <= VERY_LONG_RST;
            cfg_reg.tap_gap_ms         <= TAP_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/bgc_step.sv
// ---------------------------------------------------------------------------
// bgc_step: one sample of gesture classification
// debounce, press length grading and tap sequence closing, combinational
// ---------------------------------------------------------------------------
module bgc_step
    import bgc_pkg::*;
(
    input  bgc_cfg_t          cfg,
    input  bgc_state_t        state,
    input  logic              level,
    input  logic [TIME_W-1:0] now,
    output bgc_state_t        state_next,
    output bgc_result_t       result
);

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] press_len;
    logic [TIME_W-1:0] since_tap;
    logic [TIME_W-1:0] hold_len;
    logic              change_ok;
    logic              tap_done;
    action_t           press_act;

    always_comb
    begin
        since_change = now - state.last_change;
        press_len    = now - state.press_start;
        change_ok    = (level != state.stable_level)
                    && (since_change > TIME_W'(cfg.debounce_ms));

        state_next = state;
        press_act  = ACT_NONE;

        if (change_ok)
        begin
            state_next.stable_level = level;
            state_next.last_change  = now;
            if (!level)
            begin
                state_next.press_start = now;
            end
            else if (press_len >= TIME_W'(cfg.very_long_press_ms))
            begin
                press_act = ACT_MENU;
            end
            else if (press_len >= TIME_W'(cfg.long_press_ms))
            begin
                press_act = ACT_SELECT;
            end
            else
            begin
                // short press: one more tap, saturating
                if (state.tap_count < TAP_MAX)
                begin
                    state_next.tap_count = state.tap_count + TAP_W'(1);
                end
                state_next.tap_start = now;
            end
        end

        since_tap = now - state_next.tap_start;
        tap_done  = (state_next.tap_count != '0)
                 && (since_tap > TIME_W'(cfg.tap_gap_ms));

        result.action = press_act;
        if (tap_done)
        begin
            if (state_next.tap_count >= TAP_MAX)
            begin
                result.action = ACT_CANCEL;
            end
            else
            begin
                result.action = action_t'(4'(state_next.tap_count));
            end
            state_next.tap_count = '0;
        end

        hold_len       = now - state_next.press_start;
        result.pressed = !state_next.stable_level;
        result.hold_ms = state_next.stable_level ? '0 : HOLD_W'(hold_len);
    end

endmodule

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// testbench: button gesture classifier check
// drives timestamped pin samples through the sample channel, predicts every
// result word from an internal model of debounce, tap counting and press
// classification, and compares each result word field by field
// ---------------------------------------------------------------------------
module testbench;
    import bgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 6;     // room for the input and result registers to empty, plus margin
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_WORDS    = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 sample_valid;
    logic                 sample_ready;
    logic                 raw_level;
    logic [STAMP_W-1:0]   now_ms;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [3:0]           action;
    logic                 pressed;
    logic [HOLD_W-1:0]    hold_ms;

    // thresholds and gesture state as the block should hold them
    bgc_cfg_t          thr;
    logic              m_level;
    logic [TIME_W-1:0] m_last_change;
    logic [TIME_W-1:0] m_press_start;
    logic [TIME_W-1:0] m_tap_start;
    logic [TAP_W-1:0]  m_taps;

    // predicted result words, oldest first
    bgc_result_t expected_gestures[$];

    logic [STAMP_W-1:0] stamp_ms;        // running timestamp of the stimulus
    bit                 idle_en = 1'b1;  // random gaps and stalls allowed
    int                 samples_sent = 0;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    int                 ready_stall = 0;

    button_gesture_classifier uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .raw_level    (raw_level),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .action       (action),
        .pressed      (pressed),
        .hold_ms      (hold_ms)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // gesture model
    // ------------------------------------------------------------------

    // state after reset, thresholds back to their reset values
    task automatic clear_gesture_model();
        thr.debounce_ms        = DEBOUNCE_RST;
        thr.long_press_ms      = LONG_RST;
        thr.very_long_press_ms = VERY_LONG_RST;
        thr.tap_gap_ms         = TAP_GAP_RST;
        m_level       = 1'b1;
        m_last_change = '0;
        m_press_start = '0;
        m_tap_start   = '0;
        m_taps        = '0;
    endtask

    // one accepted sample word: update the state, queue the result word
    function automatic void classify_sample(input logic lvl, input logic [STAMP_W-1:0] stamp);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] dur;
        action_t           act;
        bgc_result_t       r;
        t   = TIME_W'(stamp);
        act = ACT_NONE;
        // a level change only counts past the debounce window
        if (lvl != m_level && TIME_W'(t - m_last_change) > TIME_W'(thr.debounce_ms))
        begin
            m_level       = lvl;
            m_last_change = t;
            if (!lvl)
            begin
                m_press_start = t;
            end
            else
            begin
                dur = t - m_press_start;
                if (dur >= TIME_W'(thr.very_long_press_ms))
                    act = ACT_MENU;
                else if (dur >= TIME_W'(thr.long_press_ms))
                    act = ACT_SELECT;
                else
                begin
                    // short press is a tap, count saturates
                    if (m_taps < TAP_MAX)
                        m_taps = m_taps + 1'b1;
                    m_tap_start = t;
                end
            end
        end
        // tap sequence ends after the gap, and wins over a press action
        if (m_taps != '0 && TIME_W'(t - m_tap_start) > TIME_W'(thr.tap_gap_ms))
        begin
            act    = (m_taps >= TAP_MAX) ? ACT_CANCEL : action_t'({1'b0, m_taps});
            m_taps = '0;
        end
        r.action  = act;
        r.pressed = !m_level;
        r.hold_ms = m_level ? '0 : HOLD_W'(t - m_press_start);
        expected_gestures.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, checking, watchdog
    // ------------------------------------------------------------------

    // ready drops in random bursts while idling is on
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (ready_stall > 0)
        begin
            ready_stall  <= ready_stall - 1;
            result_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            ready_stall  <= $urandom_range(0, 5);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // every accepted result word against the oldest prediction
    always @(posedge clk)
    begin : check_results
        bgc_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_gestures.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: action %0d pressed %0b hold %0d",
                             action, pressed, hold_ms);
            end
            else
            begin
                want = expected_gestures.pop_front();
                if (action !== want.action || pressed !== want.pressed ||
                    hold_ms !== want.hold_ms)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected action %0d pressed %0b hold %0d,",
                                  " got action %0d pressed %0b hold %0d"},
                                 want.action, want.pressed, want.hold_ms,
                                 action, pressed, hold_ms);
                end
            end
        end
    end

    // run ends when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------

    // one sample word, with an optional random gap before it
    task automatic send_sample(input logic lvl, input logic [STAMP_W-1:0] stamp);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid = 1'b1;
        raw_level    = lvl;
        now_ms       = stamp;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        classify_sample(lvl, stamp);
        samples_sent++;
        @(negedge clk);
        sample_valid = 1'b0;
    endtask

    // advance the timestamp by dt ms, then sample
    task automatic sample_after(input logic lvl, input int unsigned dt);
        stamp_ms = stamp_ms + dt;
        send_sample(lvl, stamp_ms);
    endtask

    // hold the sender until every predicted word is back, then let the pipe empty
    task automatic drain();
        while (expected_gestures.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_threshold(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            CFG_DEBOUNCE:  thr.debounce_ms        = value;
            CFG_LONG:      thr.long_press_ms      = value;
            CFG_VERY_LONG: thr.very_long_press_ms = value;
            CFG_TAP_GAP:   thr.tap_gap_ms         = value;
            default:       ;
        endcase
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                  input logic [CFG_W-1:0] vlng, input logic [CFG_W-1:0] gap);
        drain();
        write_threshold(CFG_DEBOUNCE, deb);
        write_threshold(CFG_LONG, lng);
        write_threshold(CFG_VERY_LONG, vlng);
        write_threshold(CFG_TAP_GAP, gap);
    endtask

    // a delay around a threshold: on it, one either side, or well past it
    function automatic int unsigned near(input int unsigned edge_ms);
        case ($urandom_range(0, 4))
            0:       return edge_ms;
            1:       return edge_ms + 1;
            2:       return (edge_ms == 0) ? 0 : edge_ms - 1;
            default: return edge_ms + $urandom_range(1, 300);
        endcase
    endfunction

    // just past the debounce window
    function automatic int unsigned settle_dt();
        return thr.debounce_ms + 1 + $urandom_range(0, 20);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // bounce rejection at and inside the window, a single tap becoming start
    task automatic test_debounce_and_taps();
        stamp_ms = '0;
        sample_after(1'b1, 10);    // released, no change
        sample_after(1'b0, 20);    // inside the window
        sample_after(1'b0, 20);    // exactly on the window, still rejected
        sample_after(1'b0, 1);     // press accepted
        sample_after(1'b1, 30);    // bounce on release
        sample_after(1'b1, 70);    // release, one tap pending
        sample_after(1'b1, 400);   // gap reached but not exceeded
        sample_after(1'b1, 1);     // gap exceeded, start
    endtask

    // select on the long threshold, menu, and a tap end overriding select
    task automatic test_press_actions();
        sample_after(1'b0, 100);
        sample_after(1'b1, 1000);
        sample_after(1'b0, 100);
        sample_after(1'b1, 3000);
        sample_after(1'b0, 100);
        sample_after(1'b1, 100);   // tap
        sample_after(1'b0, 100);
        sample_after(1'b1, 1200);  // select and tap end in the same word
    endtask

    // long and very long presses leave a pending tap in place
    task automatic test_pending_taps_kept();
        set_thresholds(16'd20, 16'd500, 16'd2000, 16'd5000);
        sample_after(1'b0, 100);
        sample_after(1'b1, 100);
        sample_after(1'b0, 100);
        sample_after(1'b1, 600);
        sample_after(1'b0, 100);
        sample_after(1'b1, 2500);
        sample_after(1'b1, 5001);
    endtask

    // nine taps saturate the count to cancel, across the timestamp wrap
    task automatic test_tap_saturation_wrap();
        set_thresholds(16'd0, 16'd1000, 16'd3000, 16'd400);
        stamp_ms = 32'hFFFF_FFC0;
        sample_after(1'b0, 5);
        sample_after(1'b0, 0);     // same stamp, no time passed
        repeat (8)
        begin
            sample_after(1'b1, 5);
            sample_after(1'b0, 5);
        end
        sample_after(1'b1, 5);
        sample_after(1'b1, 401);
    endtask

    // zero thresholds: every release is menu, or select once menu is out of reach
    task automatic test_zero_thresholds();
        set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        sample_after(1'b0, 1);
        sample_after(1'b1, 1);
        drain();
        write_threshold(CFG_VERY_LONG, 16'hFFFF);
        sample_after(1'b0, 1);
        sample_after(1'b1, 1);
    endtask

    // all thresholds at their maximum
    task automatic test_max_thresholds();
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sample_after(1'b0, 65536);
        sample_after(1'b1, 65535);  // on the debounce window, rejected
        sample_after(1'b1, 1);      // 65536 held, menu
    endtask

    // one random gesture shaped by the current thresholds
    task automatic random_gesture();
        int unsigned taps;
        int unsigned dur;
        int unsigned part;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                taps = $urandom_range(1, 9);
                repeat (taps)
                begin
                    sample_after(1'b0, settle_dt());
                    if ($urandom_range(0, 3) == 0)
                        sample_after(1'b1, $urandom_range(0, thr.debounce_ms));
                    sample_after(1'b1, settle_dt());
                end
                sample_after(1'b1, near(thr.tap_gap_ms));
                sample_after(1'b1, near(thr.tap_gap_ms));
            end
            5, 6, 7:
            begin
                // hold around one of the press thresholds, sampled mid-hold
                dur  = near(($urandom_range(0, 2) == 0) ? thr.very_long_press_ms
                                                        : thr.long_press_ms);
                part = $urandom_range(0, dur);
                sample_after(1'b0, settle_dt());
                sample_after(1'b0, part);
                sample_after(1'b1, dur - part);
            end
            8:
            begin
                // noise: random levels, sometimes a random jump of the clock
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                        stamp_ms = $urandom();
                    sample_after(1'($urandom_range(0, 1)), $urandom_range(0, 5000));
                end
            end
            default:
            begin
                // bounce train around the debounce window
                repeat ($urandom_range(2, 6))
                    sample_after(1'($urandom_range(0, 1)),
                                 $urandom_range(0, thr.debounce_ms + 2));
            end
        endcase
    endtask

    // random thresholds per phase, well-formed gestures with noise mixed in
    task automatic test_random_gestures();
        int          phase_end;
        int unsigned deb;
        int unsigned lng;
        int unsigned vlng;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            deb  = $urandom_range(0, 60);
            lng  = $urandom_range(20, 1500);
            vlng = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lng)
                                              : lng + $urandom_range(0, 2500);
            case ($urandom_range(0, 4))
                0:       set_thresholds(DEBOUNCE_RST, LONG_RST, VERY_LONG_RST, TAP_GAP_RST);
                1:       set_thresholds($urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                                        $urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                                        $urandom_range(0, 1) ? 16'hFFFF : 16'd0,
                                        $urandom_range(0, 1) ? 16'hFFFF : 16'd0);
                default: set_thresholds(16'(deb), 16'(lng), 16'(vlng),
                                        16'($urandom_range(deb + 1, 900)));
            endcase
            // the last phase runs with no gaps and no stalls
            if (phase == RANDOM_PHASES - 1)
                idle_en = 1'b0;
            phase_end = samples_sent + PHASE_WORDS;
            while (samples_sent < phase_end)
            begin
                random_gesture();
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DEBOUNCE;
        cfg_data     = '0;
        sample_valid = 1'b0;
        raw_level    = 1'b1;
        now_ms       = '0;
        stamp_ms     = '0;
        clear_gesture_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_debounce_and_taps();
        test_press_actions();
        test_pending_taps_kept();
        test_tap_saturation_wrap();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_gestures();

        // every word back, then a few more cycles for stray results
        drain();
        if (mismatches == 0 && expected_gestures.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
